// ===== rtl/core/feedback_delay_wet_dry_assert.svh =====
// Assertion macros for the feedback delay echo block.
// Used by the top level; the checks refer to clk and rst_n in the including scope.
// Under SYNTHESIS the macros expand to nothing.
`ifndef FEEDBACK_DELAY_WET_DRY_ASSERT_SVH
`define FEEDBACK_DELAY_WET_DRY_ASSERT_SVH

`ifndef SYNTHESIS
`define FDWD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fdwd check failed");
`define FDWD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fdwd reset check failed");
`else
`define FDWD_ASSERT(lbl, prop)
`define FDWD_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/core/fdwd_pkg.sv =====
// Shared constants and types for the feedback delay echo block.
// No dependencies; compiled before every other file of the block.
package fdwd_pkg;

  localparam int DELAY_W    = 15;
  localparam int GAIN_W     = 17;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd32768;
  localparam logic [DELAY_W-1:0] DELAY_RST = 15'd480;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET      = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/core/fdwd_chan_if.sv =====
// Valid/ready channel interfaces for the feedback delay echo block.
// One interface for the input samples and one for the mixed results; no dependencies.
interface fdwd_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdwd_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/fdwd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read and a write of the same address in one cycle return the old contents.
// No dependencies.
module fdwd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/feedback_delay_wet_dry.sv =====
// Feedback delay echo with wet/dry mix: top level.
// Depends on fdwd_pkg, fdwd_chan_if (fdwd_in_if, fdwd_out_if), fdwd_ram and
// feedback_delay_wet_dry_assert.svh.
//
//   channel   direction  handshake             payload
//   in_chan   in         valid/ready           sample_in, signed SAMPLE_BITS
//   out_chan  out        valid/ready           sample_out, signed SAMPLE_BITS
//   APB       in         psel/penable/pwrite   paddr 4 bits, pwdata/prdata 32 bits
//
// One item is taken per cycle unless stalled, set by the loop through the feedback
// multiplier and the store write port, with forwarding of the entry written at the same
// edge. The store read issues at the accepting edge; the rounded mix passes stage 2 into
// the output register. Reset is synchronous; a wrap flag beside the write position marks
// which entries hold data, so no clearing pass is needed. A stalled output lets the two
// stages behind it fill; three items are then held before in_chan.ready drops.
`include "feedback_delay_wet_dry_assert.svh"

module feedback_delay_wet_dry #(
  parameter int STORE_DEPTH = 32768,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fdwd_in_if.sink                          in_chan,
  fdwd_out_if.source                       out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fdwd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fdwd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fdwd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  import fdwd_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SB = SAMPLE_BITS;
  // Gain enters the multipliers as an 18-bit signed operand.
  localparam int PW = SB + GAIN_W + 1;

  localparam logic [AW:0]   DEPTH_C  = (AW+1)'(STORE_DEPTH);
  localparam logic [AW-1:0] WP_LAST  = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] DMOD_RST = AW'(int'(DELAY_RST) % STORE_DEPTH);

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [PW-1:0] RND_H = PW'(32768);

  // ---------------------------------------------------------------------------
  // Configuration registers. The raw values are kept for read back; clamped
  // gains and the delay reduced modulo the store depth are kept beside them for
  // the sample path, which sees the raw delay only in its zero-delay bypass test.
  // ---------------------------------------------------------------------------
  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  fb_gain_r;
  logic [GAIN_W-1:0]  wet_gain_r;
  logic [GAIN_W-1:0]  fb_c_r;
  logic [GAIN_W-1:0]  wet_c_r;
  logic [GAIN_W-1:0]  dry_r;
  logic [AW-1:0]      dmod_r;

  logic               cfg_wr;
  cfg_reg_t           cfg_idx;
  logic [DELAY_W-1:0] cfg_delay;
  logic [GAIN_W-1:0]  cfg_gain;
  logic [GAIN_W-1:0]  cfg_gain_c;
  logic [AW-1:0]      dmod_calc;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = cfg_reg_t'(paddr[3:2]);
  assign cfg_delay  = pwdata[DELAY_W-1:0];
  assign cfg_gain   = pwdata[GAIN_W-1:0];
  assign cfg_gain_c = (cfg_gain > GAIN_ONE) ? GAIN_ONE : cfg_gain;

  // Delay modulo the store depth. When the store is shallower than the delay
  // range, the quotient comes from a multiply by the scaled reciprocal, which
  // is exact for every 15-bit delay, and the remainder follows from it.
  if (STORE_DEPTH < (1 << DELAY_W)) begin : g_dmod_recip
    localparam int SH = DELAY_W + AW;
    localparam int MW = DELAY_W + 2;
    localparam logic [MW-1:0] RECIP =
      MW'(((longint'(1) << SH) + longint'(STORE_DEPTH) - 1) / longint'(STORE_DEPTH));
    logic [DELAY_W+MW-1:0] prod;
    logic [DELAY_W-1:0]    quo;
    logic [DELAY_W-1:0]    rem;
    assign prod      = {{MW{1'b0}}, cfg_delay} * {{DELAY_W{1'b0}}, RECIP};
    assign quo       = DELAY_W'(prod >> SH);
    assign rem       = cfg_delay - DELAY_W'(quo * DELAY_W'(STORE_DEPTH));
    assign dmod_calc = AW'(rem);
  end else begin : g_dmod_wide
    assign dmod_calc = AW'(cfg_delay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= DELAY_RST;
      dmod_r     <= DMOD_RST;
      fb_gain_r  <= GAIN_RST;
      fb_c_r     <= GAIN_RST;
      wet_gain_r <= GAIN_RST;
      wet_c_r    <= GAIN_RST;
      dry_r      <= GAIN_ONE - GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DELAY: begin
          delay_r <= cfg_delay;
          dmod_r  <= dmod_calc;
        end
        REG_FEEDBACK: begin
          fb_gain_r <= cfg_gain;
          fb_c_r    <= cfg_gain_c;
        end
        REG_WET: begin
          wet_gain_r <= cfg_gain;
          wet_c_r    <= cfg_gain_c;
          dry_r      <= GAIN_ONE - cfg_gain_c;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DELAY:    prdata = APB_DATA_W'(delay_r);
      REG_FEEDBACK: prdata = APB_DATA_W'(fb_gain_r);
      REG_WET:      prdata = APB_DATA_W'(wet_gain_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Elastic pipeline control. Each stage loads when it is empty or when the
  // stage ahead of it is loading, so a stalled output still lets the stages
  // behind it fill.
  // ---------------------------------------------------------------------------
  logic s1_v_r;
  logic s2_v_r;
  logic out_v_r;
  logic out_en;
  logic s2_en;
  logic s1_en;
  logic in_acc;
  logic wr;

  assign out_en = !out_v_r || out_chan.ready;
  assign s2_en  = !s2_v_r || out_en;
  assign s1_en  = !s1_v_r || s2_en;
  assign in_acc = in_chan.valid && s1_en;
  // The item in stage 1 writes its store entry as it moves on.
  assign wr     = s1_v_r && s2_en;

  assign in_chan.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= in_acc;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (out_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Stage 1 payload, loaded with each accepted item.
  logic signed [SB-1:0] s1_x_r;
  logic [AW-1:0]        s1_wp_r;
  logic                 s1_bypass_r;
  logic                 s1_fill_r;
  logic                 s1_fwd_r;
  logic signed [SB-1:0] s1_fwd_data_r;

  // ---------------------------------------------------------------------------
  // Stage 0: write position, read address and the store read.
  // Entries are written in address order from zero after reset, so an entry
  // holds data once the write position has passed it or has wrapped once;
  // otherwise it reads as zero.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_inc;
  logic          wrapped_r;
  logic [AW:0]   rp_diff;
  logic [AW-1:0] rp;
  logic          bypass;
  logic          fill_ok;
  logic          fwd_hit;

  logic signed [SB-1:0] stored;
  logic [SB-1:0]        rd_data;

  assign wp_inc  = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
  assign rp_diff = {1'b0, wp_r} - {1'b0, dmod_r};
  assign rp      = rp_diff[AW] ? AW'(rp_diff + DEPTH_C) : rp_diff[AW-1:0];
  assign bypass  = (delay_r == '0);
  assign fill_ok = wrapped_r || (rp < wp_r);
  // The item leaving stage 1 writes at the same edge as this read; the store
  // returns the old contents, so the new value is captured alongside.
  assign fwd_hit = wr && (s1_wp_r == rp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (in_acc) begin
      wp_r      <= wp_inc;
      wrapped_r <= wrapped_r || (wp_r == WP_LAST);
    end
  end

  fdwd_ram #(
    .WIDTH (SB),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr),
    .wr_addr (s1_wp_r),
    .wr_data (stored),
    .rd_en   (in_acc),
    .rd_addr (rp),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r        <= in_chan.sample_in;
      s1_wp_r       <= wp_r;
      s1_bypass_r   <= bypass;
      s1_fill_r     <= fill_ok;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= stored;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick the delayed sample, compute the feedback value that goes
  // back into the store, and form the two mix products.
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0]   y;
  logic signed [PW-1:0]   fb_prod;
  logic signed [PW-1:0]   fb_rsum;
  logic signed [SB+1:0]   fb_q;
  logic signed [SB+2:0]   st_sum;
  logic signed [PW-1:0]   wet_prod;
  logic signed [PW-1:0]   dry_prod;

  always_comb begin
    if (s1_bypass_r) begin
      y = s1_x_r;
    end else if (s1_fwd_r) begin
      y = s1_fwd_data_r;
    end else if (s1_fill_r) begin
      y = $signed(rd_data);
    end else begin
      y = '0;
    end
  end

  always_comb begin
    fb_prod = $signed({1'b0, fb_c_r}) * y;
    // Round to nearest with ties upward: add one half, then floor.
    fb_rsum = fb_prod + RND_H;
    fb_q    = fb_rsum[PW-1:16];
    st_sum  = (SB+3)'(s1_x_r) + (SB+3)'(fb_q);
    if (st_sum > (SB+3)'(S_MAX)) begin
      stored = S_MAX;
    end else if (st_sum < (SB+3)'(S_MIN)) begin
      stored = S_MIN;
    end else begin
      stored = st_sum[SB-1:0];
    end
  end

  assign wet_prod = $signed({1'b0, wet_c_r}) * y;
  assign dry_prod = $signed({1'b0, dry_r}) * s1_x_r;

  logic signed [PW-1:0] s2_wet_r;
  logic signed [PW-1:0] s2_dry_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_wet_r <= wet_prod;
      s2_dry_r <= dry_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sum the wet and dry products, round, saturate into the output
  // register.
  // ---------------------------------------------------------------------------
  logic signed [PW:0]   mix_sum;
  logic signed [SB+2:0] mix_q;
  logic signed [SB-1:0] mix_sat;
  logic signed [SB-1:0] sample_out_r;

  always_comb begin
    mix_sum = (PW+1)'(s2_wet_r) + (PW+1)'(s2_dry_r) + (PW+1)'(RND_H);
    mix_q   = mix_sum[PW:16];
    if (mix_q > (SB+3)'(S_MAX)) begin
      mix_sat = S_MAX;
    end else if (mix_q < (SB+3)'(S_MIN)) begin
      mix_sat = S_MIN;
    end else begin
      mix_sat = mix_q[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      sample_out_r <= mix_sat;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.sample_out = sample_out_r;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `FDWD_ASSERT_RST(a_reset_empties, !rst_n |=> (!s1_v_r && !s2_v_r && !out_v_r))
  `FDWD_ASSERT(a_wp_steps, in_acc |=> (wp_r == $past(wp_inc)))
  `FDWD_ASSERT(a_rd_holds, (s1_v_r && !s2_en) |=> $stable(rd_data))
  `FDWD_ASSERT(a_wr_in_range, wr |-> (s1_wp_r <= WP_LAST))

endmodule
